@@ hdl/tq_pkg.sv @@
package tq_pkg;

  localparam int unsigned QueueDepthDefault = 64;

  localparam logic [1:0] KIND_SCHED  = 2'd0;
  localparam logic [1:0] KIND_FRONT  = 2'd1;
  localparam logic [1:0] KIND_POP    = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned EntW   = 16;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned EntryW = TimeW + EntW + CodeW;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] delay_ticks;
    logic [15:0] entity_id;
    logic [15:0] event_code;
  } tq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] event_time;
    logic [15:0] out_entity;
    logic [15:0] out_code;
    logic [6:0]  removed_count;
    logic [6:0]  chain_size;
  } tq_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic set_full;
    logic set_empty;
    logic rd_prev;
    logic wr_new;
    logic shift;
    logic front;
    logic pop_take;
    logic rem_start;
    logic rem_step;
    logic publish;
  } tq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       idx_zero;
    logic       time_le;
    logic       rem_last;
    logic       out_free;
  } tq_stat_t;

endpackage

@@ hdl/timed_event_queue.sv @@
// Schedule shifts each later entry back one slot, reading and comparing it in turn, until
// the new entry's slot is found (ring memory with one registered read port); remove
// compacts the held entries in order (one memory read per cycle during compaction).
// Throughput: one operation at a time; the next is taken once the result is staged.
// Reset: rst_ni clears count, head and current time; entry memory is not cleared.
module timed_event_queue
  import tq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  tq_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output tq_out_t out_data_o
);

  tq_cmd_t  cmd;
  tq_stat_t stat;

  tq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  tq_datapath #(
    .QueueDepth(QueueDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

@@ hdl/tq_ram.sv @@
module tq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tq_ctrl.sv @@
module tq_ctrl
  import tq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tq_stat_t stat_i,
  output tq_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCH_STEP, S_SCH_CHK, S_POP, S_REM, S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.kind)
          KIND_SCHED: begin
            if (stat_i.full) begin
              cmd_o.set_full = 1'b1;
              state_d        = S_FIN;
            end else begin
              state_d = S_SCH_STEP;
            end
          end
          KIND_FRONT: begin
            if (stat_i.full) cmd_o.set_full = 1'b1;
            else cmd_o.front = 1'b1;
            state_d = S_FIN;
          end
          KIND_POP: begin
            if (stat_i.empty) begin
              cmd_o.set_empty = 1'b1;
              state_d         = S_FIN;
            end else begin
              state_d = S_POP;
            end
          end
          default: begin
            if (stat_i.empty) begin
              state_d = S_FIN;
            end else begin
              cmd_o.rem_start = 1'b1;
              state_d         = S_REM;
            end
          end
        endcase
      end
      S_SCH_STEP: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_new = 1'b1;
          state_d      = S_FIN;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_SCH_CHK;
        end
      end
      S_SCH_CHK: begin
        if (stat_i.time_le) begin
          cmd_o.wr_new = 1'b1;
          state_d      = S_FIN;
        end else begin
          cmd_o.shift = 1'b1;
          state_d     = S_SCH_STEP;
        end
      end
      S_POP: begin
        cmd_o.pop_take = 1'b1;
        state_d        = S_FIN;
      end
      S_REM: begin
        cmd_o.rem_step = 1'b1;
        if (stat_i.rem_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/tq_datapath.sv @@
module tq_datapath
  import tq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tq_in_t   in_data_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output tq_out_t  out_data_o,
  input  tq_cmd_t  cmd_i,
  output tq_stat_t stat_o
);

  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam int unsigned SW = AW + 2;
  localparam logic [CW-1:0] DepthC = CW'(QueueDepth);
  localparam logic [SW-1:0] DepthS = SW'(QueueDepth);
  localparam logic [AW-1:0] LastA  = AW'(QueueDepth - 1);

  logic [AW-1:0]    head_q;
  logic [CW-1:0]    count_q, idx_q, wptr_q;
  logic [TimeW-1:0] now_q, res_time_q;
  logic [1:0]       kind_q, res_status_q;
  logic [EntW-1:0]  ent_q, res_ent_q;
  logic [CodeW-1:0] code_q, res_code_q;
  logic [CW-1:0]    removed_q;
  logic             out_valid_q;
  tq_out_t          out_q;

  logic             we;
  logic [AW-1:0]    waddr, raddr, head_dec;
  logic [EntryW-1:0] wdata, rdata;
  logic [TimeW-1:0] rd_time;
  logic [EntW-1:0]  rd_ent;
  logic [CodeW-1:0] rd_code;
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] sat_time;
  logic             match;

  // logical position to ring address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(l);
    if (s >= DepthS) s = s - DepthS;
    return s[AW-1:0];
  endfunction

  assign {rd_time, rd_ent, rd_code} = rdata;
  assign match    = (rd_ent == ent_q);
  assign head_dec = (head_q == '0) ? LastA : head_q - AW'(1);
  assign sum      = {1'b0, now_q} + (TimeW + 1)'(in_data_i.delay_ticks);
  assign sat_time = sum[TimeW] ? '1 : sum[TimeW-1:0];

  always_comb begin
    raddr = head_q;
    if (cmd_i.rd_prev) raddr = phys(head_q, idx_q - CW'(1));
    else if (cmd_i.rem_step) raddr = phys(head_q, idx_q + CW'(1));
  end

  always_comb begin
    we    = cmd_i.wr_new | cmd_i.shift | cmd_i.front | (cmd_i.rem_step & ~match);
    wdata = rdata;
    waddr = phys(head_q, idx_q);
    if (cmd_i.wr_new || cmd_i.front) wdata = {res_time_q, ent_q, code_q};
    if (cmd_i.front) waddr = head_dec;
    else if (cmd_i.rem_step) waddr = phys(head_q, wptr_q);
  end

  tq_ram #(
    .Width(EntryW),
    .Depth(QueueDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_new || cmd_i.front) count_q <= count_q + CW'(1);
      if (cmd_i.front) head_q <= head_dec;
      if (cmd_i.pop_take) begin
        now_q   <= rd_time;
        head_q  <= (head_q == LastA) ? '0 : head_q + AW'(1);
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.rem_step && (idx_q + CW'(1) == count_q)) begin
        count_q <= match ? wptr_q : wptr_q + CW'(1);
      end
      if (cmd_i.publish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q       <= in_data_i.kind;
      ent_q        <= in_data_i.entity_id;
      code_q       <= in_data_i.event_code;
      idx_q        <= count_q;
      res_status_q <= STATUS_OK;
      res_ent_q    <= '0;
      res_code_q   <= '0;
      removed_q    <= '0;
      case (in_data_i.kind)
        KIND_SCHED: res_time_q <= sat_time;
        KIND_FRONT: res_time_q <= now_q;
        default:    res_time_q <= '0;
      endcase
    end
    if (cmd_i.set_full) res_status_q <= STATUS_FULL;
    if (cmd_i.set_empty) res_status_q <= STATUS_EMPTY;
    if (cmd_i.shift) idx_q <= idx_q - CW'(1);
    if (cmd_i.pop_take) begin
      res_time_q <= rd_time;
      res_ent_q  <= rd_ent;
      res_code_q <= rd_code;
    end
    if (cmd_i.rem_start) begin
      idx_q  <= '0;
      wptr_q <= '0;
    end
    if (cmd_i.rem_step) begin
      idx_q <= idx_q + CW'(1);
      if (match) removed_q <= removed_q + CW'(1);
      else wptr_q <= wptr_q + CW'(1);
    end
    if (cmd_i.publish) begin
      out_q.status        <= res_status_q;
      out_q.event_time    <= res_time_q;
      out_q.out_entity    <= res_ent_q;
      out_q.out_code      <= res_code_q;
      out_q.removed_count <= 7'(removed_q);
      out_q.chain_size    <= 7'(count_q);
    end
  end

  assign stat_o.kind     = kind_q;
  assign stat_o.full     = (count_q == DepthC);
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.time_le  = (rd_time <= res_time_q);
  assign stat_o.rem_last = (idx_q + CW'(1) == count_q);
  assign stat_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/tq_checker.sv @@
module tq_checker
  import tq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input tq_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_full_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_FULL |->
      out_data_o.chain_size == 7'(QueueDepth))
    else $error("full status with wrong chain size");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_EMPTY |->
      out_data_o.chain_size == '0 && out_data_o.event_time == '0)
    else $error("empty status with data");

  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STATUS_OK |-> out_data_o.removed_count == '0)
    else $error("removed count on failed insert or pop");

endmodule

bind timed_event_queue tq_checker #(
  .QueueDepth(QueueDepth)
) u_tq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

@@ dv/timed_event_queue_tb.sv @@
module timed_event_queue_tb;
  import tq_pkg::*;

  localparam int unsigned Depth = 64;
  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned StallLimit = 20000;

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_ready_o;
  tq_in_t  in_data_i;
  logic    out_valid_o;
  logic    out_ready_i;
  tq_out_t out_data_o;

  timed_event_queue u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // shadow of the sorted queue
  logic [47:0] q_time[$];
  logic [15:0] q_ent[$];
  logic [15:0] q_code[$];
  logic [47:0] sim_now;

  tq_out_t pending_results[$];
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  bit          hold_off;
  bit          timed_out;

  function automatic tq_out_t apply_event_op(tq_in_t op);
    tq_out_t     res;
    logic [48:0] sum;
    logic [47:0] t;
    int          pos;
    int          cnt;
    res = '0;
    case (op.kind)
      KIND_SCHED, KIND_FRONT: begin
        if (op.kind == KIND_SCHED) begin
          sum = {1'b0, sim_now} + {17'd0, op.delay_ticks};
          t = sum[48] ? TimeMax : sum[47:0];
        end else begin
          t = sim_now;
        end
        res.event_time = t;
        if (q_time.size() >= Depth) begin
          res.status = STATUS_FULL;
        end else begin
          pos = 0;
          if (op.kind == KIND_SCHED) begin
            while (pos < q_time.size() && q_time[pos] <= t) pos++;
          end
          q_time.insert(pos, t);
          q_ent.insert(pos, op.entity_id);
          q_code.insert(pos, op.event_code);
        end
      end
      KIND_POP: begin
        if (q_time.size() == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.event_time = q_time[0];
          res.out_entity = q_ent[0];
          res.out_code = q_code[0];
          sim_now = q_time[0];
          q_time.delete(0);
          q_ent.delete(0);
          q_code.delete(0);
        end
      end
      default: begin
        cnt = 0;
        for (int i = q_time.size() - 1; i >= 0; i--) begin
          if (q_ent[i] == op.entity_id) begin
            q_time.delete(i);
            q_ent.delete(i);
            q_code.delete(i);
            cnt++;
          end
        end
        res.removed_count = 7'(cnt);
      end
    endcase
    res.status = res.status;
    res.chain_size = 7'(q_time.size());
    return res;
  endfunction

  task automatic stop_input;
    in_valid_i <= 1'b0;
  endtask

  task automatic send_op(logic [1:0] kind, logic [31:0] delay, logic [15:0] ent,
                         logic [15:0] code);
    tq_in_t op;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    op.kind = kind;
    op.delay_ticks = delay;
    op.entity_id = ent;
    op.event_code = code;
    in_valid_i <= 1'b1;
    in_data_i <= op;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.insert(pending_results.size(), apply_event_op(op));
  endtask

  task automatic drain;
    stop_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_delay();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(40);
    endcase
  endfunction

  task automatic test_directed;
    send_op(KIND_POP, 0, 16'hFFFF, 16'hFFFF);       // empty pop
    send_op(KIND_REMOVE, 0, 16'h1234, 0);           // remove, no match
    send_op(KIND_SCHED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_op(KIND_SCHED, 32'd5, 16'h0000, 16'h0000);
    send_op(KIND_SCHED, 32'd5, 16'h0001, 16'hAAAA); // same time goes after
    send_op(KIND_FRONT, 0, 16'h0002, 16'h5555);
    send_op(KIND_POP, 0, 0, 0);
    send_op(KIND_POP, 0, 0, 0);
    send_op(KIND_POP, 0, 0, 0);
    send_op(KIND_POP, 0, 0, 0);                     // now at 32'hFFFF_FFFF
    // large delays on a large current time; the sums stay below the 48-bit maximum
    send_op(KIND_SCHED, 32'hFFFF_FFFF, 16'h0003, 16'h0001);
    send_op(KIND_SCHED, 32'h8000_0000, 16'h0003, 16'h0002);
    send_op(KIND_REMOVE, 0, 16'h0003, 0);
    send_op(KIND_POP, 0, 0, 0);
    send_op(KIND_POP, 0, 0, 0);
    drain();
  endtask

  task automatic test_fill;
    // fill past capacity, remove a whole entity, refill with one entity and remove it, then flush
    for (int i = 0; i < Depth + 4; i++) begin
      send_op((i % 5 == 0) ? KIND_FRONT : KIND_SCHED, rand_delay(), 16'(i % 3),
              16'($urandom()));
    end
    send_op(KIND_REMOVE, 0, 16'd1, 0);
    for (int i = 0; i < 30; i++) send_op(KIND_SCHED, $urandom_range(9), 16'd7, 16'($urandom()));
    send_op(KIND_REMOVE, 0, 16'd7, 0);
    while (q_time.size() != 0) send_op(KIND_POP, 0, 0, 0);
    drain();
  endtask

  task automatic test_random(int unsigned n);
    logic [1:0] kind;
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) kind = KIND_SCHED;
      else if (r < 55) kind = KIND_FRONT;
      else if (r < 92) kind = KIND_POP;
      else kind = KIND_REMOVE;
      send_op(kind, rand_delay(),
              ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(7)),
              16'($urandom()));
    end
    drain();
  endtask

  task automatic test_backpressure;
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) send_op(KIND_SCHED, $urandom_range(50), 16'(i), 16'(i));
    stop_input();
    wait (hold_off == 1'b0);
    while (q_time.size() != 0) send_op(KIND_POP, 0, 0, 0);
    drain();
  endtask

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_off) begin
      repeat (400) @(posedge clk_i);
      hold_off <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    tq_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_data_o.status !== want.status
            || out_data_o.event_time !== want.event_time
            || out_data_o.out_entity !== want.out_entity
            || out_data_o.out_code !== want.out_code
            || out_data_o.removed_count !== want.removed_count
            || out_data_o.chain_size !== want.chain_size) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %h actual %h", want, out_data_o);
          end
        end
      end
    end
  end

  // watchdog on transfer-free cycles
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    hold_off = 1'b0;
    timed_out = 1'b0;
    quiet_cycles = 0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sim_now = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill();
    test_backpressure();
    test_random(500);
    send_idle_pct = 46;
    test_random(450);
    send_idle_pct = 0;
    recv_stall_pct = 46;
    test_random(450);
    send_idle_pct = 35;
    recv_stall_pct = 35;
    test_random(450);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
